@@ hdl/cei_pkg.sv @@
// ----------------------------------------------------------------------------
// cei_pkg: shared constants, types and arithmetic helpers
// Holds the Hastings coefficients in Q.30, the pipeline depths and the
// truncating fixed-point product used by the elliptic integral datapath.
// ----------------------------------------------------------------------------
package cei_pkg;

   localparam int unsigned INPUT_FRAC_BITS_DEF = 32;

   // Logarithm unit: leading-one search, normalize, one stage per squaring
   // step, base-2 to natural conversion in three stages.
   localparam int unsigned LOG_STEPS    = 30;
   localparam int unsigned LOG_LAT      = LOG_STEPS + 5;
   localparam int unsigned HORNER_STEPS = 4;
   localparam int unsigned NUM_POLY     = 4;
   localparam int unsigned M30_DLY      = LOG_LAT - 1;
   // Square, form m, logarithm, two product stages, output register.
   localparam int unsigned PIPE_LAT     = LOG_LAT + 5;

   localparam int unsigned POLY_KA = 0;
   localparam int unsigned POLY_KB = 1;
   localparam int unsigned POLY_EA = 2;
   localparam int unsigned POLY_EB = 3;

   typedef logic [62:0] m62_type;
   typedef logic [30:0] m30_type;
   typedef logic [34:0] fix35_type;
   typedef logic [31:0] coef_type;

   // Decimal constants are scaled by 1e11; 2^30 / 1e11 = 2^19 / 5^11.
   localparam longint unsigned Q30_MUL  = 64'd524288;
   localparam longint unsigned Q30_HALF = 64'd24414062;
   localparam longint unsigned Q30_DIV  = 64'd48828125;

   localparam coef_type LN2_Q30 = coef_type'((64'd69314718056 * Q30_MUL + Q30_HALF) / Q30_DIV);

   localparam coef_type COEF [NUM_POLY][HORNER_STEPS+1] = '{
      '{coef_type'((64'd138629436112 * Q30_MUL + Q30_HALF) / Q30_DIV),
        coef_type'((64'd9666344259   * Q30_MUL + Q30_HALF) / Q30_DIV),
        coef_type'((64'd3590092383   * Q30_MUL + Q30_HALF) / Q30_DIV),
        coef_type'((64'd3742563713   * Q30_MUL + Q30_HALF) / Q30_DIV),
        coef_type'((64'd1451196212   * Q30_MUL + Q30_HALF) / Q30_DIV)},
      '{coef_type'((64'd50000000000  * Q30_MUL + Q30_HALF) / Q30_DIV),
        coef_type'((64'd12498593597  * Q30_MUL + Q30_HALF) / Q30_DIV),
        coef_type'((64'd6880248576   * Q30_MUL + Q30_HALF) / Q30_DIV),
        coef_type'((64'd3328355346   * Q30_MUL + Q30_HALF) / Q30_DIV),
        coef_type'((64'd441787012    * Q30_MUL + Q30_HALF) / Q30_DIV)},
      '{coef_type'((64'd100000000000 * Q30_MUL + Q30_HALF) / Q30_DIV),
        coef_type'((64'd44325141463  * Q30_MUL + Q30_HALF) / Q30_DIV),
        coef_type'((64'd6260601220   * Q30_MUL + Q30_HALF) / Q30_DIV),
        coef_type'((64'd4757383546   * Q30_MUL + Q30_HALF) / Q30_DIV),
        coef_type'((64'd1736506451   * Q30_MUL + Q30_HALF) / Q30_DIV)},
      '{coef_type'(0),
        coef_type'((64'd24998368310  * Q30_MUL + Q30_HALF) / Q30_DIV),
        coef_type'((64'd9200180037   * Q30_MUL + Q30_HALF) / Q30_DIV),
        coef_type'((64'd4069697526   * Q30_MUL + Q30_HALF) / Q30_DIV),
        coef_type'((64'd526449639    * Q30_MUL + Q30_HALF) / Q30_DIV)}
   };

   // Truncated Q.30 product of an accumulator and m.
   function automatic logic [32:0] mul30(input coef_type a, input m30_type b);
      logic [62:0] p;
      p = 63'(a) * 63'(b);
      return p[62:30];
   endfunction

endpackage

@@ hdl/cei_log.sv @@
// ----------------------------------------------------------------------------
// cei_log: pipelined negative natural logarithm
// Takes m in Q1.62 (at least 2^-31) and returns -ln(m) in Q.30. The base-2
// fraction comes from one squaring step per stage; ln 2 scaling follows.
// ----------------------------------------------------------------------------
module cei_log import cei_pkg::*; (
   input  logic      clock,
   input  logic      enable,
   input  m62_type   m62,
   output fix35_type neg_ln
);

   logic [4:0]            lz_sh_in;
   logic [4:0]            lz_sh_ff;
   m62_type               lz_m_ff;
   m62_type               norm;

   logic [30:0]           x_ff    [LOG_STEPS+1];
   logic [LOG_STEPS-1:0]  frac_ff [LOG_STEPS+1];
   logic [4:0]            sh_ff   [LOG_STEPS+1];
   logic [30:0]           x_in    [LOG_STEPS];
   logic [LOG_STEPS-1:0]  frac_in [LOG_STEPS];
   logic [61:0]           sqr     [LOG_STEPS];

   fix35_type             l2_ff;
   logic [48:0]           ph_ff;
   logic [45:0]           pl_ff;
   logic [65:0]           tsum;
   fix35_type             t_ff;

   // Leading one between bit 62 and bit 31; the highest set bit wins.
   always_comb begin
      lz_sh_in = 5'd31;
      for (int i = 31; i <= 62; i++) begin
         if (m62[i]) begin
            lz_sh_in = 5'(62 - i);
         end
      end
   end

   assign norm = lz_m_ff << lz_sh_ff;

   always_comb begin
      for (int i = 0; i < LOG_STEPS; i++) begin
         sqr[i]     = 62'(x_ff[i]) * 62'(x_ff[i]);
         frac_in[i] = frac_ff[i];
         frac_in[i][LOG_STEPS-1-i] = sqr[i][61];
         x_in[i]    = sqr[i][61] ? sqr[i][61:31] : sqr[i][60:30];
      end
   end

   assign tsum = {ph_ff, 16'd0} + 66'(pl_ff);

   always_ff @(posedge clock) begin
      if (enable) begin
         lz_sh_ff   <= lz_sh_in;
         lz_m_ff    <= m62;
         x_ff[0]    <= norm[62:32];
         frac_ff[0] <= '0;
         sh_ff[0]   <= lz_sh_ff;
         for (int i = 0; i < LOG_STEPS; i++) begin
            x_ff[i+1]    <= x_in[i];
            frac_ff[i+1] <= frac_in[i];
            sh_ff[i+1]   <= sh_ff[i];
         end
         l2_ff <= {sh_ff[LOG_STEPS], 30'd0} - 35'(frac_ff[LOG_STEPS]);
         ph_ff <= 49'(LN2_Q30[29:0]) * 49'(l2_ff[34:16]);
         pl_ff <= 46'(LN2_Q30[29:0]) * 46'(l2_ff[15:0]);
         t_ff  <= tsum[64:30];
      end
   end

   assign neg_ln = t_ff;

endmodule

@@ hdl/complete_elliptic_integrals_top.sv @@
// ----------------------------------------------------------------------------
// complete_elliptic_integrals_top: Hastings approximation of K(k) and E(k)
// One transaction is taken every cycle unless a result waits under stall.
// The 30-step squaring chain of the logarithm sets depth.
// The whole pipeline holds while a result waits under stall.
// Synchronous reset clears only the valid bits; the datapath registers are not reset.
// ----------------------------------------------------------------------------
module complete_elliptic_integrals_top import cei_pkg::*; #(
   parameter int unsigned INPUT_FRAC_BITS = INPUT_FRAC_BITS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [31:0] req_modulus,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [31:0] rsp_first_kind,
   output logic [31:0] rsp_second_kind
);

   logic        en;
   logic [31:0] k32;
   logic [63:0] sq_ff;
   m62_type     m62_ff;
   m30_type     m30_dly_ff [M30_DLY];
   fix35_type   t;

   coef_type    h_in [NUM_POLY][HORNER_STEPS];
   coef_type    h_ff [NUM_POLY][HORNER_STEPS];

   logic [50:0] kb_hi_ff, eb_hi_ff;
   logic [47:0] kb_lo_ff, eb_lo_ff;
   coef_type    ka_a_ff, ea_a_ff, ka_b_ff, ea_b_ff;
   logic [66:0] kprod_sum, eprod_sum;
   logic [36:0] kprod_ff, eprod_ff;
   logic [38:0] ksum;
   logic [37:0] esum;
   logic [31:0] kout_ff, eout_ff;

   logic [PIPE_LAT-1:0] v_ff;

   assign en        = !v_ff[PIPE_LAT-1] || !rsp_stall;
   assign req_stall = !en;

   generate
      if (INPUT_FRAC_BITS >= 32) begin : g_narrow
         assign k32 = req_modulus >> (INPUT_FRAC_BITS - 32);
      end else begin : g_widen
         assign k32 = (33'(req_modulus) >= (33'd1 << INPUT_FRAC_BITS)) ? '1
                    : 32'(req_modulus << (32 - INPUT_FRAC_BITS));
      end
   endgenerate

   cei_log u_log (
      .clock  (clock),
      .enable (en),
      .m62    (m62_ff),
      .neg_ln (t)
   );

   // Horner steps run at the tail so that the last one lines up with -ln m.
   always_comb begin
      for (int p = 0; p < NUM_POLY; p++) begin
         h_in[p][0] = coef_type'(COEF[p][HORNER_STEPS-1]
                      + mul30(COEF[p][HORNER_STEPS], m30_dly_ff[LOG_LAT-5]));
         for (int j = 1; j < HORNER_STEPS; j++) begin
            h_in[p][j] = coef_type'(COEF[p][HORNER_STEPS-1-j]
                         + mul30(h_ff[p][j-1], m30_dly_ff[LOG_LAT-5+j]));
         end
      end
   end

   assign kprod_sum = {kb_hi_ff, 16'd0} + 67'(kb_lo_ff);
   assign eprod_sum = {eb_hi_ff, 16'd0} + 67'(eb_lo_ff);
   assign ksum      = 39'(ka_b_ff) + 39'(kprod_ff) + 39'd4;
   assign esum      = 38'(ea_b_ff) + 38'(eprod_ff);

   always_ff @(posedge clock) begin
      if (en) begin
         sq_ff         <= 64'(k32) * 64'(k32);
         m62_ff        <= 63'(64'h4000_0000_0000_0000 - (sq_ff >> 2));
         m30_dly_ff[0] <= m62_ff[62:32];
         for (int i = 1; i < M30_DLY; i++) begin
            m30_dly_ff[i] <= m30_dly_ff[i-1];
         end
         h_ff <= h_in;

         kb_hi_ff <= 51'(h_ff[POLY_KB][HORNER_STEPS-1]) * 51'(t[34:16]);
         kb_lo_ff <= 48'(h_ff[POLY_KB][HORNER_STEPS-1]) * 48'(t[15:0]);
         eb_hi_ff <= 51'(h_ff[POLY_EB][HORNER_STEPS-1]) * 51'(t[34:16]);
         eb_lo_ff <= 48'(h_ff[POLY_EB][HORNER_STEPS-1]) * 48'(t[15:0]);
         ka_a_ff  <= h_ff[POLY_KA][HORNER_STEPS-1];
         ea_a_ff  <= h_ff[POLY_EA][HORNER_STEPS-1];

         kprod_ff <= kprod_sum[66:30];
         eprod_ff <= eprod_sum[66:30];
         ka_b_ff  <= ka_a_ff;
         ea_b_ff  <= ea_a_ff;

         // K drops to Q5.27 with rounding; both results saturate.
         kout_ff <= (|ksum[38:35]) ? '1 : ksum[34:3];
         eout_ff <= (|esum[37:32]) ? '1 : esum[31:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else if (en) begin
         v_ff <= {v_ff[PIPE_LAT-2:0], req_valid};
      end
   end

   assign rsp_valid       = v_ff[PIPE_LAT-1];
   assign rsp_first_kind  = kout_ff;
   assign rsp_second_kind = eout_ff;

endmodule

@@ hdl/cei_checker.sv @@
// ----------------------------------------------------------------------------
// cei_checker: port-level checks for the elliptic integral block
// Watches the handshakes and the range of E(k) at the top-level ports.
// ----------------------------------------------------------------------------
module cei_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_stall,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic [31:0] rsp_first_kind,
   input logic [31:0] rsp_second_kind
);

   // The input side is only held back by a result that is waiting.
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (rsp_valid && rsp_stall))
      else $error("input stalled without a waiting result");

   a_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_first_kind)
                                    && $stable(rsp_second_kind)))
      else $error("stalled result changed or vanished");

   a_reset: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid right after reset");

   // Every term of E is non-negative on top of the leading one.
   a_e_floor: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_second_kind >= 32'h4000_0000))
      else $error("second kind below one");

endmodule

bind complete_elliptic_integrals_top cei_checker u_cei_checker (
   .clock           (clock),
   .reset           (reset),
   .req_stall       (req_stall),
   .rsp_valid       (rsp_valid),
   .rsp_stall       (rsp_stall),
   .rsp_first_kind  (rsp_first_kind),
   .rsp_second_kind (rsp_second_kind)
);
